@@ rtl/core/dews_pkg.sv @@
// Shared types, sizes and codes for the delay-extend block with window sums.
`default_nettype none
package dews_pkg;

  // Field and storage sizes.
  localparam int CHAN_BITS      = 4;
  localparam int MAX_CHANNELS   = 1 << CHAN_BITS;
  localparam int BLK_BITS       = 4;
  localparam int MAX_EXTEND     = 1 << BLK_BITS;
  localparam int HIST_IDX_BITS  = 10;
  localparam int HIST_ADDR_BITS = CHAN_BITS + HIST_IDX_BITS;
  localparam int HIST_WORDS     = 1 << HIST_ADDR_BITS;
  localparam int SAMPLE_BITS    = 16;
  localparam int SUM_BITS       = 25;
  localparam int ROW_BITS       = 8;
  localparam int ROW_COUNT      = 1 << ROW_BITS;

  // Configuration registers.
  localparam int CNT_BITS      = 5;
  localparam int WIN_BITS      = HIST_IDX_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = WIN_BITS;
  localparam int ROW_FULL_BITS = BLK_BITS + CNT_BITS + 1;

  localparam logic [CNT_BITS-1:0] CHAN_COUNT_RST = CNT_BITS'(16);
  localparam logic [CNT_BITS-1:0] EXTEND_RST     = CNT_BITS'(1);
  localparam logic [WIN_BITS-1:0] WINDOW_RST     = WIN_BITS'(512);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_EXTEND_FACTOR = 2'd1,
    CFG_DEMEAN_WINDOW = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } dews_state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic issue_read;
    logic update;
    logic next_block;
  } dews_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic zero_blocks;
    logic last_block;
    logic out_free;
  } dews_status_t;

endpackage
`default_nettype wire

@@ rtl/core/dews_ctrl.sv @@
// Sequencer for clearing, request intake and the per-block read/update loop.
`default_nettype none
module dews_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  dews_pkg::dews_status_t sts_i,
  output dews_pkg::dews_cmd_t    cmd_o
);
  import dews_pkg::*;

  dews_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // With no delay blocks the sample is only stored.
          if (!sts_i.zero_blocks) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.issue_read = 1'b1;
        state_d          = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          if (sts_i.last_block) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_block = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  a_update_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> sts_i.out_free)
    else $error("result loaded while the output register is occupied");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.update && sts_i.last_block) |=> (state_q == ST_IDLE))
    else $error("run did not end after its last block");

  a_read_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue_read |=> (state_q == ST_UPDATE))
    else $error("memory read not followed by the update step");

endmodule
`default_nettype wire

@@ rtl/core/dews_datapath.sv @@
// Configuration, history and sum memories, address arithmetic and result register.
`default_nettype none
module dews_datapath (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [dews_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire  [dews_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire  [dews_pkg::CHAN_BITS-1:0]       channel_index_i,
  input  wire  signed [dews_pkg::SAMPLE_BITS-1:0] sample_value_i,
  output logic [dews_pkg::ROW_BITS-1:0]        extended_row_o,
  output logic signed [dews_pkg::SAMPLE_BITS-1:0] delayed_value_o,
  output logic signed [dews_pkg::SUM_BITS-1:0] window_sum_o,
  output logic                                 last_of_run_o,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  input  dews_pkg::dews_cmd_t                  cmd_i,
  output dews_pkg::dews_status_t               sts_o
);
  import dews_pkg::*;

  // Configuration registers.
  logic [CNT_BITS-1:0] chan_count_q;
  logic [CNT_BITS-1:0] extend_q;
  logic [WIN_BITS-1:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= CHAN_COUNT_RST;
      extend_q     <= EXTEND_RST;
      window_q     <= WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHANNEL_COUNT: chan_count_q <= cfg_data_i[CNT_BITS-1:0];
        CFG_EXTEND_FACTOR: extend_q     <= cfg_data_i[CNT_BITS-1:0];
        CFG_DEMEAN_WINDOW: window_q     <= cfg_data_i[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel ring write pointers.
  logic [HIST_IDX_BITS-1:0] pos_q [MAX_CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        pos_q[i] <= '0;
      end
    end else if (cmd_i.accept) begin
      pos_q[channel_index_i] <= pos_q[channel_index_i] + 1'b1;
    end
  end

  // Clear sweep counter, runs once after reset.
  logic [HIST_ADDR_BITS-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Run context of the request in progress.
  logic [CHAN_BITS-1:0]     ch_q;
  logic [HIST_IDX_BITS-1:0] newest_q;
  logic [BLK_BITS-1:0]      blk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q     <= channel_index_i;
      newest_q <= pos_q[channel_index_i];
      blk_q    <= '0;
    end else if (cmd_i.next_block) begin
      blk_q <= blk_q + 1'b1;
    end
  end

  // Ring offsets wrap naturally in the index width.
  logic [HIST_IDX_BITS-1:0] dly_idx;
  logic [HIST_IDX_BITS-1:0] old_idx;
  logic [ROW_FULL_BITS-1:0] row_full;

  assign dly_idx  = newest_q - HIST_IDX_BITS'(blk_q);
  assign old_idx  = dly_idx - window_q;
  assign row_full = ROW_FULL_BITS'(blk_q) * ROW_FULL_BITS'(chan_count_q)
                  + ROW_FULL_BITS'(ch_q);

  // History memory.
  logic [SAMPLE_BITS-1:0] hist_mem [HIST_WORDS];
  logic [SAMPLE_BITS-1:0] dly_rd_q;
  logic [SAMPLE_BITS-1:0] old_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      hist_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.accept) begin
      hist_mem[{channel_index_i, pos_q[channel_index_i]}] <= sample_value_i;
    end
    if (cmd_i.issue_read) begin
      dly_rd_q <= hist_mem[{ch_q, dly_idx}];
      old_rd_q <= hist_mem[{ch_q, old_idx}];
    end
  end

  // Row sum memory, cleared during the first rows of the history sweep.
  logic [SUM_BITS-1:0] sum_mem [ROW_COUNT];
  logic [SUM_BITS-1:0] sum_rd_q;
  logic [ROW_BITS-1:0] row_q;
  logic [SUM_BITS-1:0] new_sum;
  logic                sum_clear;

  assign sum_clear = cmd_i.clear && (clr_cnt_q[HIST_ADDR_BITS-1:ROW_BITS] == '0);
  assign new_sum   = sum_rd_q
                   + {{(SUM_BITS-SAMPLE_BITS){dly_rd_q[SAMPLE_BITS-1]}}, dly_rd_q}
                   - {{(SUM_BITS-SAMPLE_BITS){old_rd_q[SAMPLE_BITS-1]}}, old_rd_q};

  always_ff @(posedge clk_i) begin
    if (sum_clear) begin
      sum_mem[clr_cnt_q[ROW_BITS-1:0]] <= '0;
    end else if (cmd_i.update) begin
      sum_mem[row_q] <= new_sum;
    end
    if (cmd_i.issue_read) begin
      sum_rd_q <= sum_mem[row_full[ROW_BITS-1:0]];
      row_q    <= row_full[ROW_BITS-1:0];
    end
  end

  // Last block index after clamping the extension factor.
  logic [BLK_BITS-1:0] last_blk;

  assign last_blk = (extend_q > CNT_BITS'(MAX_EXTEND)) ? BLK_BITS'(MAX_EXTEND - 1)
                                                       : BLK_BITS'(extend_q - 1'b1);

  // Result register.
  logic                   out_valid_q;
  logic [ROW_BITS-1:0]    row_out_q;
  logic [SAMPLE_BITS-1:0] dly_out_q;
  logic [SUM_BITS-1:0]    sum_out_q;
  logic                   last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      row_out_q  <= row_q;
      dly_out_q  <= dly_rd_q;
      sum_out_q  <= new_sum;
      last_out_q <= sts_o.last_block;
    end
  end

  assign extended_row_o  = row_out_q;
  assign delayed_value_o = dly_out_q;
  assign window_sum_o    = sum_out_q;
  assign last_of_run_o   = last_out_q;
  assign out_valid_o     = out_valid_q;

  assign sts_o.clear_last  = &clr_cnt_q;
  assign sts_o.zero_blocks = (extend_q == '0);
  assign sts_o.last_block  = (blk_q == last_blk);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  a_run_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (blk_q == '0))
    else $error("block counter not cleared at the start of a run");

  a_block_steps_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.next_block |=> (blk_q == $past(blk_q) + 1'b1))
    else $error("block counter did not advance by one");

  a_update_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> out_valid_q)
    else $error("updated result not presented");

endmodule
`default_nettype wire

@@ rtl/core/delay_extend_with_window_sums.sv @@
// Top level: time-delay embedding of channel samples with per-row window sums.
//
//   Channel   Direction  Handshake              Payload
//   in        request    in_valid_i/in_stall_o  channel_index_i, sample_value_i
//   out       result     out_valid_o/out_stall_i extended_row_o, delayed_value_o,
//                                                window_sum_o, last_of_run_o
//   cfg       write      cfg_we_i               cfg_index_i, cfg_data_i
//
// A request is taken in the idle state, where its sample is stored; then each block,
// blocks being the clamped extend_factor (none when it is zero), is a memory read
// state on the history and row sum memories, then an update state that writes the row sum.
// After reset a clearing pass over all 16384 history words zeroes the history and the sums;
// requests are stalled meanwhile, configuration writes are taken.
// A stalled result holds the update loop; a new request is taken while the last
// result of the previous one still waits.
`default_nettype none
module delay_extend_with_window_sums (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [dews_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire  [dews_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [dews_pkg::CHAN_BITS-1:0]       channel_index_i,
  input  wire  signed [dews_pkg::SAMPLE_BITS-1:0] sample_value_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [dews_pkg::ROW_BITS-1:0]        extended_row_o,
  output logic signed [dews_pkg::SAMPLE_BITS-1:0] delayed_value_o,
  output logic signed [dews_pkg::SUM_BITS-1:0] window_sum_o,
  output logic                                 last_of_run_o
);
  import dews_pkg::*;

  dews_cmd_t    cmd;
  dews_status_t sts;

  dews_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dews_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .channel_index_i (channel_index_i),
    .sample_value_i  (sample_value_i),
    .extended_row_o  (extended_row_o),
    .delayed_value_o (delayed_value_o),
    .window_sum_o    (window_sum_o),
    .last_of_run_o   (last_of_run_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
`default_nettype wire
